[design/bmm_pkg.sv]
`default_nettype none

package bmm_pkg;

  // Array limits
  localparam int MAX_ROWS  = 16;
  localparam int MAX_INNER = 64;
  localparam int MAX_COLS  = 64;
  localparam int MAX_BATCH = 256;

  localparam int ROW_W   = 4;   // row index field
  localparam int INNER_W = 6;   // address into a row of A
  localparam int COL_W   = 6;   // column index field
  localparam int BATCH_W = 8;   // batch index field

  // Configuration register widths
  localparam int M_W  = 5;
  localparam int K_W  = 7;
  localparam int N_W  = 7;
  localparam int NB_W = 9;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_USED  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_COUNT = 4'd3;

  localparam int ELEM_W = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 48;

  localparam logic MODE_A = 1'b0;
  localparam logic MODE_B = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic signed [ELEM_W-1:0] element_value;
  } bmm_in_t;

  typedef struct packed {
    logic [BATCH_W-1:0]      batch_index;
    logic [ROW_W-1:0]        row_index;
    logic [COL_W-1:0]        col_index;
    logic signed [ACC_W-1:0] product_value;
    logic                    last_of_run;
  } bmm_out_t;

  // Work passed down the row cells, one cell per cycle
  typedef struct packed {
    logic                     valid;
    logic                     is_b;     // B element (else A store write)
    logic signed [ELEM_W-1:0] value;
    logic [ROW_W-1:0]         row_sel;  // A: target row; B: last active row
    logic [INNER_W-1:0]       a_addr;   // A: column of A; B: row of B
    logic [COL_W-1:0]         c_addr;   // B: column of B
    logic                     first;    // first row of B: set, not add
    logic                     last;     // last row of B: emit the sum
    logic [BATCH_W-1:0]       batch;
  } bmm_tok_t;

endpackage

`default_nettype wire

[design/batched_matrix_multiply_top.sv]
`default_nettype none

// Batched matrix multiplier: C = A * B for batch_count pairs of an M x K
// matrix A and a K x N matrix B, signed Q8.8 elements, exact Q32.16 sums.
// Feed each batch as all of A (mode 0) then all of B (mode 1), both row-major;
// an item of the wrong phase is taken and dropped. An item is taken on a
// clock edge with start high and busy low. A items, and B items outside the
// last row of B, leave busy low, but when N is 1 or 2 a B item holds busy so
// that the same column's accumulator is written back before it is read
// again. A B item of the last row ends its column: its M results leave on
// out_item, one per cycle with out_strobe high, row 0 first, the first one
// after the input register and row 0's read stage, multiply stage and
// result register; busy stays high so that bursts never overlap. The result
// port has no back-pressure: take every result in the cycle it is strobed.
// Work walks down a chain of 16 row cells, one cell per cycle; each cell
// keeps its row of A and its row of accumulators in two 64-entry memories,
// so row i finishes in the cycle after row i-1. Any write to registers 0..3
// aborts the job in progress and clamps the value into range; write them
// only while the block is idle.

module batched_matrix_multiply_top (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  bmm_pkg::bmm_in_t                 in_item,
  output logic                             out_strobe,
  output bmm_pkg::bmm_out_t                out_item,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [bmm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [bmm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bmm_pkg::*;

  // Clamped dimensions
  logic [M_W-1:0]  m_r, m_nxt;
  logic [K_W-1:0]  k_r, k_nxt;
  logic [N_W-1:0]  n_r, n_nxt;
  logic [NB_W-1:0] nb_r, nb_nxt;

  // Job position
  logic               loading_b_r, loading_b_nxt;
  logic [ROW_W-1:0]   a_row_r, a_row_nxt;
  logic [INNER_W-1:0] a_col_r, a_col_nxt;
  logic [INNER_W-1:0] b_row_r, b_row_nxt;
  logic [COL_W-1:0]   b_col_r, b_col_nxt;
  logic [BATCH_W-1:0] batch_r, batch_nxt;
  logic [ROW_W-1:0]   hold_r, hold_nxt;

  bmm_tok_t tok_r, tok_nxt;

  logic take;
  logic cfg_hit;
  logic take_a;
  logic take_b;
  logic a_col_end;
  logic a_row_end;
  logic b_col_end;
  logic b_row_end;
  logic batch_end;
  logic [ROW_W-1:0] m_last;
  logic [ROW_W-1:0] hold_burst;
  logic [ROW_W-1:0] hold_gap;

  bmm_tok_t tok_chain [MAX_ROWS+1];
  logic     cell_v    [MAX_ROWS];
  bmm_out_t cell_res  [MAX_ROWS];

  function automatic logic [M_W-1:0] clamp_m(input logic [M_W-1:0] v);
    if (v == '0) return M_W'(1);
    if (v > M_W'(MAX_ROWS)) return M_W'(MAX_ROWS);
    return v;
  endfunction

  function automatic logic [K_W-1:0] clamp_k(input logic [K_W-1:0] v);
    if (v == '0) return K_W'(1);
    if (v > K_W'(MAX_INNER)) return K_W'(MAX_INNER);
    return v;
  endfunction

  function automatic logic [N_W-1:0] clamp_n(input logic [N_W-1:0] v);
    if (v == '0) return N_W'(1);
    if (v > N_W'(MAX_COLS)) return N_W'(MAX_COLS);
    return v;
  endfunction

  function automatic logic [NB_W-1:0] clamp_nb(input logic [NB_W-1:0] v);
    if (v == '0) return NB_W'(1);
    if (v > NB_W'(MAX_BATCH)) return NB_W'(MAX_BATCH);
    return v;
  endfunction

  assign busy      = (hold_r != '0);
  assign cfg_ready = 1'b1;
  assign take      = start && !busy;
  assign cfg_hit   = cfg_valid && cfg_ready && (cfg_index == CFG_ROWS_USED ||
                     cfg_index == CFG_INNER_USED || cfg_index == CFG_COLS_USED ||
                     cfg_index == CFG_BATCH_COUNT);

  // Only items of the expected phase do anything
  assign take_a = take && !loading_b_r && (in_item.mode == MODE_A);
  assign take_b = take && loading_b_r && (in_item.mode == MODE_B);

  assign m_last    = ROW_W'(m_r - M_W'(1));
  assign a_col_end = ({1'b0, a_col_r} == K_W'(k_r - K_W'(1)));
  assign a_row_end = (a_row_r == m_last);
  assign b_col_end = ({1'b0, b_col_r} == N_W'(n_r - N_W'(1)));
  assign b_row_end = ({1'b0, b_row_r} == K_W'(k_r - K_W'(1)));
  assign batch_end = ({1'b0, batch_r} == NB_W'(nb_r - NB_W'(1)));

  // Hold off the next item until the result burst is clear, and until a
  // repeated column's accumulator has been written back
  assign hold_burst = b_row_end ? m_last : '0;
  assign hold_gap   = (n_r <= N_W'(2)) ? ROW_W'(2) : '0;

  // Configuration
  always_comb begin
    m_nxt  = m_r;
    k_nxt  = k_r;
    n_nxt  = n_r;
    nb_nxt = nb_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS_USED:   m_nxt  = clamp_m(cfg_data[M_W-1:0]);
        CFG_INNER_USED:  k_nxt  = clamp_k(cfg_data[K_W-1:0]);
        CFG_COLS_USED:   n_nxt  = clamp_n(cfg_data[N_W-1:0]);
        CFG_BATCH_COUNT: nb_nxt = clamp_nb(cfg_data[NB_W-1:0]);
        default: ;
      endcase
    end
  end

  // Position counters and the item sent into the cell chain
  always_comb begin
    loading_b_nxt = loading_b_r;
    a_row_nxt     = a_row_r;
    a_col_nxt     = a_col_r;
    b_row_nxt     = b_row_r;
    b_col_nxt     = b_col_r;
    batch_nxt     = batch_r;
    hold_nxt      = busy ? ROW_W'(hold_r - ROW_W'(1)) : '0;

    tok_nxt         = '0;
    tok_nxt.value   = in_item.element_value;
    tok_nxt.batch   = batch_r;

    if (take_a) begin
      tok_nxt.valid   = 1'b1;
      tok_nxt.is_b    = 1'b0;
      tok_nxt.row_sel = a_row_r;
      tok_nxt.a_addr  = a_col_r;
      a_col_nxt = a_col_r + INNER_W'(1);
      if (a_col_end) begin
        a_col_nxt = '0;
        a_row_nxt = a_row_r + ROW_W'(1);
        if (a_row_end) begin
          a_row_nxt     = '0;
          b_row_nxt     = '0;
          b_col_nxt     = '0;
          loading_b_nxt = 1'b1;
        end
      end
    end else if (take_b) begin
      tok_nxt.valid   = 1'b1;
      tok_nxt.is_b    = 1'b1;
      tok_nxt.row_sel = m_last;
      tok_nxt.a_addr  = b_row_r;
      tok_nxt.c_addr  = b_col_r;
      tok_nxt.first   = (b_row_r == '0);
      tok_nxt.last    = b_row_end;
      hold_nxt  = (hold_burst > hold_gap) ? hold_burst : hold_gap;
      b_col_nxt = b_col_r + COL_W'(1);
      if (b_col_end) begin
        b_col_nxt = '0;
        b_row_nxt = b_row_r + INNER_W'(1);
        if (b_row_end) begin
          b_row_nxt     = '0;
          loading_b_nxt = 1'b0;
          a_row_nxt     = '0;
          a_col_nxt     = '0;
          batch_nxt     = batch_end ? '0 : BATCH_W'(batch_r + BATCH_W'(1));
        end
      end
    end

    // Abort the job on a write to registers 0..3
    if (cfg_hit) begin
      loading_b_nxt = 1'b0;
      a_row_nxt     = '0;
      a_col_nxt     = '0;
      b_row_nxt     = '0;
      b_col_nxt     = '0;
      batch_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r         <= M_W'(MAX_ROWS);
      k_r         <= K_W'(MAX_INNER);
      n_r         <= N_W'(MAX_COLS);
      nb_r        <= NB_W'(1);
      loading_b_r <= 1'b0;
      a_row_r     <= '0;
      a_col_r     <= '0;
      b_row_r     <= '0;
      b_col_r     <= '0;
      batch_r     <= '0;
      hold_r      <= '0;
      tok_r       <= '0;
    end else begin
      m_r         <= m_nxt;
      k_r         <= k_nxt;
      n_r         <= n_nxt;
      nb_r        <= nb_nxt;
      loading_b_r <= loading_b_nxt;
      a_row_r     <= a_row_nxt;
      a_col_r     <= a_col_nxt;
      b_row_r     <= b_row_nxt;
      b_col_r     <= b_col_nxt;
      batch_r     <= batch_nxt;
      hold_r      <= hold_nxt;
      tok_r       <= tok_nxt;
    end
  end

  // Row cells: each passes the item on to the next row in the next cycle
  assign tok_chain[0] = tok_r;

  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
    bmm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_row  (ROW_W'(g)),
      .tok_in    (tok_chain[g]),
      .tok_out   (tok_chain[g+1]),
      .res_valid (cell_v[g]),
      .res       (cell_res[g])
    );
  end

  // At most one cell shows a result in any cycle; merge them
  always_comb begin
    out_strobe = 1'b0;
    out_item   = '0;
    for (int i = 0; i < MAX_ROWS; i++) begin
      if (cell_v[i]) begin
        out_strobe = 1'b1;
        out_item   = out_item | cell_res[i];
      end
    end
  end

endmodule

`default_nettype wire

[design/bmm_cell.sv]
`default_nettype none

module bmm_cell (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire [bmm_pkg::ROW_W-1:0] cell_row,
  input  bmm_pkg::bmm_tok_t       tok_in,
  output bmm_pkg::bmm_tok_t       tok_out,
  output logic                    res_valid,
  output bmm_pkg::bmm_out_t       res
);
  import bmm_pkg::*;

  logic signed [ELEM_W-1:0] a_mem   [MAX_INNER];
  logic signed [ACC_W-1:0]  acc_mem [MAX_COLS];

  bmm_tok_t tok_r;

  logic hit_a;
  logic hit_b;

  // Read stage
  logic signed [ELEM_W-1:0] a_rd_r;
  logic signed [ACC_W-1:0]  acc_rd_r;
  logic                     s1_v_r;
  logic signed [ELEM_W-1:0] s1_val_r;
  logic                     s1_first_r;
  logic                     s1_last_r;
  logic                     s1_lrow_r;
  logic [COL_W-1:0]         s1_col_r;
  logic [BATCH_W-1:0]       s1_batch_r;

  // Multiply stage
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  s2_acc_r;
  logic                     s2_v_r;
  logic                     s2_first_r;
  logic                     s2_last_r;
  logic                     s2_lrow_r;
  logic [COL_W-1:0]         s2_col_r;
  logic [BATCH_W-1:0]       s2_batch_r;

  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  sum;

  logic     res_v_r;
  bmm_out_t res_r;

  assign hit_a = tok_in.valid && !tok_in.is_b && (tok_in.row_sel == cell_row);
  assign hit_b = tok_in.valid && tok_in.is_b && (cell_row <= tok_in.row_sel);

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign sum      = s2_first_r ? prod_ext : (s2_acc_r + prod_ext);

  // Stores and payload
  always_ff @(posedge clk) begin
    if (hit_a) begin
      a_mem[tok_in.a_addr] <= tok_in.value;
    end
    a_rd_r   <= a_mem[tok_in.a_addr];
    acc_rd_r <= acc_mem[tok_in.c_addr];
    if (s2_v_r) begin
      acc_mem[s2_col_r] <= sum;
    end

    s1_val_r   <= tok_in.value;
    s1_first_r <= tok_in.first;
    s1_last_r  <= tok_in.last;
    s1_lrow_r  <= (tok_in.row_sel == cell_row);
    s1_col_r   <= tok_in.c_addr;
    s1_batch_r <= tok_in.batch;

    prod_r     <= a_rd_r * s1_val_r;
    s2_acc_r   <= acc_rd_r;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_lrow_r  <= s1_lrow_r;
    s2_col_r   <= s1_col_r;
    s2_batch_r <= s1_batch_r;

    res_r.batch_index   <= s2_batch_r;
    res_r.row_index     <= cell_row;
    res_r.col_index     <= s2_col_r;
    res_r.product_value <= sum;
    res_r.last_of_run   <= s2_lrow_r;
  end

  // Stage valids and the item handed to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      tok_r   <= tok_in;
      s1_v_r  <= hit_b;
      s2_v_r  <= s1_v_r;
      res_v_r <= s2_v_r && s2_last_r;
    end
  end

  assign tok_out   = tok_r;
  assign res_valid = res_v_r;
  assign res       = res_r;

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import bmm_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 12;
  // Deepest path through the block: 16 row cells, then the output stage.
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 60;
  localparam int REPORT_LIMIT  = 10;

  // Register indexes with no register behind them: a write must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 4'd15;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  bmm_in_t               in_item;
  logic                  out_strobe;
  bmm_out_t              out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  batched_matrix_multiply_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Shadow copy of the block: registers as written, A rows, column sums and
  // the position of the stream inside the job.
  logic [M_W-1:0]           rows_reg;
  logic [K_W-1:0]           inner_reg;
  logic [N_W-1:0]           cols_reg;
  logic [NB_W-1:0]          batches_reg;
  logic signed [ELEM_W-1:0] a_rows [MAX_ROWS*MAX_INNER];
  longint                   col_sums [MAX_ROWS*MAX_COLS];
  bit                       loading_b;
  int                       a_pos;
  int                       b_row;
  int                       b_col;
  int                       batch_num;

  bmm_out_t pending_products [$];   // products owed by the block, oldest first
  int       mismatches   = 0;
  int       gap_pct      = 0;       // chance of a sender gap after each item
  int       stall_cycles = 0;

  function automatic int clamp_dim(int v, int hi);
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  function automatic int m_dim();
    return clamp_dim(int'(rows_reg), MAX_ROWS);
  endfunction

  function automatic int k_dim();
    return clamp_dim(int'(inner_reg), MAX_INNER);
  endfunction

  function automatic int n_dim();
    return clamp_dim(int'(cols_reg), MAX_COLS);
  endfunction

  function automatic int nb_dim();
    return clamp_dim(int'(batches_reg), MAX_BATCH);
  endfunction

  // Well-formed items in one matrix pair under the current shape.
  function automatic int batch_len();
    return m_dim() * k_dim() + k_dim() * n_dim();
  endfunction

  function automatic void restart_job();
    loading_b = 1'b0;
    a_pos     = 0;
    b_row     = 0;
    b_col     = 0;
    batch_num = 0;
  endfunction

  // Mirror a register write: mask to the register width, then drop the job
  // in progress. Spare indexes leave everything untouched.
  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_ROWS_USED:   rows_reg    = data[M_W-1:0];
      CFG_INNER_USED:  inner_reg   = data[K_W-1:0];
      CFG_COLS_USED:   cols_reg    = data[N_W-1:0];
      CFG_BATCH_COUNT: batches_reg = data[NB_W-1:0];
      default:         return;
    endcase
    restart_job();
  endfunction

  // Advance the shadow by one accepted item and queue the column sums it
  // finishes. A items fill the A rows; B items fold into the sums of their
  // column, and an item of the last B row releases all M sums of that column.
  function automatic void accumulate_element(bmm_in_t it);
    int                       m;
    int                       k;
    int                       n;
    int                       i;
    int                       ai;
    int                       ci;
    logic signed [ELEM_W-1:0] val;
    longint                   total;
    bmm_out_t                 res;
    m   = m_dim();
    k   = k_dim();
    n   = n_dim();
    val = it.element_value;
    if (!loading_b) begin
      if (it.mode != MODE_A) return;
      a_rows[a_pos] = val;
      a_pos++;
      if (a_pos >= m * k) begin
        a_pos     = 0;
        b_row     = 0;
        b_col     = 0;
        loading_b = 1'b1;
      end
      return;
    end
    if (it.mode != MODE_B) return;
    for (i = 0; i < m; i++) begin
      ai    = i * k + b_row;
      ci    = i * MAX_COLS + b_col;
      total = longint'(a_rows[ai]) * longint'(val);
      if (b_row != 0) total += col_sums[ci];
      col_sums[ci] = total;
      if (b_row + 1 >= k) begin
        res.batch_index   = batch_num[BATCH_W-1:0];
        res.row_index     = i[ROW_W-1:0];
        res.col_index     = b_col[COL_W-1:0];
        res.product_value = total[ACC_W-1:0];
        res.last_of_run   = (i + 1 == m);
        pending_products.push_back(res);
      end
    end
    b_col++;
    if (b_col >= n) begin
      b_col = 0;
      b_row++;
      if (b_row >= k) begin
        b_row     = 0;
        loading_b = 1'b0;
        a_pos     = 0;
        batch_num++;
        if (batch_num >= nb_dim()) batch_num = 0;
      end
    end
  endfunction

  function automatic logic signed [ELEM_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return '0;
      3:       return -16'sd1;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Mostly small dimensions keep batches short; now and then go wide.
  function automatic int pick_dim(int common_hi, int rare_hi);
    if ($urandom_range(9) == 0) return $urandom_range(1, rare_hi);
    return $urandom_range(1, common_hi);
  endfunction

  // Present one item, hold it until the block takes it, then update the
  // shadow. Busy is sampled at the edge, before the block updates it. Leave
  // start high unless a gap is drawn, so back-to-back items never lower and
  // raise start in the same step.
  task automatic send_item(bmm_in_t it);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    accumulate_element(it);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_element(logic mode, logic signed [ELEM_W-1:0] value);
    bmm_in_t it;
    it.mode          = mode;
    it.element_value = value;
    send_item(it);
  endtask

  // Drop start and wait out every owed product; always waits for a clock
  // edge so a following item never raises start in this same step.
  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_products.size() != 0);
  endtask

  // Write only while idle: drain, let anything still walking the row cells
  // (A writes, dropped items) clear, then complete the handshake.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx,
                                logic [CFG_DATA_W-1:0] data);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_register(idx, data);
  endtask

  task automatic set_shape(int rows, int inner, int cols, int batches);
    write_register(CFG_ROWS_USED,   CFG_DATA_W'(rows));
    write_register(CFG_INNER_USED,  CFG_DATA_W'(inner));
    write_register(CFG_COLS_USED,   CFG_DATA_W'(cols));
    write_register(CFG_BATCH_COUNT, CFG_DATA_W'(batches));
  endtask

  // Stream count well-formed items in the order the shadow expects. Mix in
  // wrong-phase items at noise_pct; they are dropped and not counted. Rarely
  // pause the stream until every owed product is out.
  task automatic feed(int count, int noise_pct);
    logic mode;
    while (count > 0) begin
      if ($urandom_range(99) < noise_pct) begin
        mode = loading_b ? MODE_A : MODE_B;
      end else begin
        mode = loading_b ? MODE_B : MODE_A;
        count--;
      end
      send_element(mode, pick_value());
      if ($urandom_range(199) == 0) hold_until_drained();
    end
  endtask

  // Out of reset the block waits for A under the reset shape: a B item must
  // vanish. Start an A load that the next register write throws away.
  task automatic test_default_shape_drop();
    send_element(MODE_B, 16'sh1234);
    send_element(MODE_A, 16'sh0100);
    send_element(MODE_A, -16'sd256);
  endtask

  // 2x2 by 2x2 with the element extremes and one wrong-phase item in each
  // phase, then a second pair and a wrapped job starting again at pair zero.
  task automatic test_basic_pair();
    set_shape(2, 2, 2, 2);
    send_element(MODE_B, 16'sh0101);
    send_element(MODE_A, 16'sh7FFF);
    send_element(MODE_A, 16'sh8000);
    send_element(MODE_A, -16'sd1);
    send_element(MODE_A, 16'sh0100);
    send_element(MODE_A, 16'sh0200);
    send_element(MODE_B, 16'sh8000);
    send_element(MODE_B, 16'sh7FFF);
    send_element(MODE_B, '0);
    send_element(MODE_B, -16'sd1);
    feed(batch_len(), 0);
    feed(batch_len(), 0);
  endtask

  // K of one: the first B row is the last, every B item emits its column.
  task automatic test_single_inner();
    set_shape(3, 1, 2, 1);
    feed(batch_len(), 10);
  endtask

  // Spare indexes must not disturb a job halfway through its A load; a real
  // register write in the middle of the B phase must restart it.
  task automatic test_abort_and_spare_index();
    set_shape(2, 3, 2, 2);
    feed(3, 0);
    write_register(CFG_SPARE_HI, '1);
    write_register(CFG_SPARE_LO, 9'h0AA);
    feed(5, 0);
    write_register(CFG_COLS_USED, CFG_DATA_W'(2));
    feed(2 * batch_len(), 0);
  endtask

  task automatic test_register_extremes();
    // Zero reads as one in every register.
    set_shape(0, 0, 0, 0);
    feed(batch_len(), 0);
    // Upper data bits are masked off; whatever remains above range saturates.
    write_register(CFG_ROWS_USED,   9'h1FF);
    write_register(CFG_INNER_USED,  9'h181);
    write_register(CFG_COLS_USED,   9'h001);
    write_register(CFG_BATCH_COUNT, 9'h1FF);
    feed(3 * batch_len(), 0);
    // Full 16-row bursts; pause with the job open until they are all out.
    set_shape(16, 1, 4, 1);
    feed(17, 0);
    hold_until_drained();
    feed(3, 0);
    // Longest dot product, then the widest row of B.
    set_shape(1, 64, 1, 1);
    feed(batch_len(), 5);
    set_shape(1, 1, 64, 1);
    feed(batch_len(), 5);
    // Largest shape and batch count: start the A load, abort it later.
    set_shape(16, 127, 127, 256);
    feed(40, 0);
  endtask

  // Random shapes and content in three sender phases: no gaps, frequent
  // gaps, occasional gaps. Some jobs run twice back to back; some are cut
  // short and abandoned to the next register write. Jobs too long for the
  // share of a phase are always cut.
  task automatic test_random_jobs();
    int p;
    int len;
    int jobs;
    int cut;
    int sent;
    sent = 0;
    for (p = 0; p < 3; p++) begin
      gap_pct = (p == 0) ? 0 : (p == 1) ? 54 : 14;
      while (sent < (p + 1) * RANDOM_ITEMS / 3) begin
        set_shape(pick_dim(4, 16), pick_dim(4, 12), pick_dim(4, 10),
                  $urandom_range(1, 3));
        len = batch_len() * nb_dim();
        if ($urandom_range(99) < 15 || len > RANDOM_ITEMS / 3) begin
          cut = $urandom_range(1, (len - 1 < RANDOM_ITEMS / 3) ? len - 1
                                                               : RANDOM_ITEMS / 3);
          feed(cut, 8);
          sent += cut;
        end else begin
          jobs = $urandom_range(1, 2);
          feed(jobs * len, 8);
          sent += jobs * len;
        end
      end
    end
    gap_pct = 0;
  endtask

  // Check every strobed product against the oldest owed one. The block has
  // no back-pressure, so each strobe is one product, taken at this edge.
  always @(posedge clk) begin : check_products
    bmm_out_t want;
    if (rst_n && out_strobe) begin
      if (pending_products.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected product: batch %0d row %0d col %0d value %0d last %0b",
                   out_item.batch_index, out_item.row_index, out_item.col_index,
                   out_item.product_value, out_item.last_of_run);
      end else begin
        want = pending_products.pop_front();
        if (out_item.batch_index !== want.batch_index ||
            out_item.row_index !== want.row_index ||
            out_item.col_index !== want.col_index ||
            out_item.product_value !== want.product_value ||
            out_item.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch: want b%0d r%0d c%0d %0d l%0b got b%0d r%0d c%0d %0d l%0b",
                     want.batch_index, want.row_index, want.col_index,
                     want.product_value, want.last_of_run,
                     out_item.batch_index, out_item.row_index, out_item.col_index,
                     out_item.product_value, out_item.last_of_run);
        end
      end
    end
  end

  // Watchdog: any item, product or register write moving resets the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    // Drive every input from time zero; hold reset for the first cycles.
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rows_reg    = M_W'(MAX_ROWS);
    inner_reg   = K_W'(MAX_INNER);
    cols_reg    = N_W'(MAX_COLS);
    batches_reg = NB_W'(1);
    restart_job();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_shape_drop();
    test_basic_pair();
    test_single_inner();
    test_abort_and_spare_index();
    test_register_extremes();
    test_random_jobs();

    // Drain, then give anything late a chance to show up as unexpected.
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_products.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
